// File: sv/lpam_pkg.sv
package lpam_pkg;

    // Width of the payload ports on both channels
    localparam int unsigned FIELD_WIDTH = 32;

    // Answer when no odd prime exists at or below the limit
    localparam int unsigned NO_PRIME = 1;

    // Trial divisors start here; odd candidates never have an even factor
    localparam int unsigned FIRST_DIVISOR = 3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_TEST,
        ST_DIV,
        ST_FINISH
    } lpam_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture limit, form first candidate
        logic cand_step;   // candidate -= 2
        logic div_init;    // divisor = 3, square = 9
        logic div_start;   // launch remainder unit
        logic div_step;    // divisor += 2, square updated
        logic out_load;    // candidate into output register
    } lpam_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cand_lt3;    // candidate below three: search exhausted
        logic sq_gt_cand;  // divisor squared above candidate: prime
        logic div_busy;    // remainder unit running
        logic rem_zero;    // last remainder was zero: composite
        logic out_free;    // output register can take a new beat
    } lpam_status_t;

endpackage

// File: sv/lpam_div.sv
module lpam_div #(
    parameter int unsigned VALUE_WIDTH = 32,
    parameter int unsigned DIV_WIDTH   = 18
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0]   divisor,
    output logic                   busy,
    output logic                   rem_zero
);

    localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] dividend_reg;
    logic [DIV_WIDTH-1:0]   divisor_reg;
    logic [DIV_WIDTH-1:0]   rem_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;

    logic [DIV_WIDTH:0]     shifted;
    logic [DIV_WIDTH:0]     diff;
    logic                   fits;
    logic [DIV_WIDTH-1:0]   rem_next;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        shifted  = {rem_reg, dividend_reg[VALUE_WIDTH-1]};
        diff     = shifted - {1'b0, divisor_reg};
        fits     = (shifted >= {1'b0, divisor_reg});
        rem_next = fits ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
    end

    // Control: busy and bit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(VALUE_WIDTH);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Operands and partial remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
            rem_reg      <= '0;
        end else if (busy_reg) begin
            dividend_reg <= {dividend_reg[VALUE_WIDTH-2:0], 1'b0};
            rem_reg      <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign rem_zero = (rem_reg == '0);

    // Partial remainder always below the divisor while running
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < divisor_reg))
        else $error("remainder not below divisor");

    // Never relaunched mid-division
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("division restarted while busy");

endmodule

// File: sv/lpam_datapath.sv
module lpam_datapath #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lpam_pkg::lpam_cmd_t                cmd,
    output lpam_pkg::lpam_status_t             status,
    input  logic [lpam_pkg::FIELD_WIDTH-1:0]   s_upper_limit,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lpam_pkg::FIELD_WIDTH-1:0]   m_largest_prime
);

    // Divisor never passes 2^ceil(W/2)+2; its square stays below 2^(W+2)
    localparam int unsigned DW = (VALUE_WIDTH + 1) / 2 + 2;
    localparam int unsigned SW = VALUE_WIDTH + 3;

    logic [VALUE_WIDTH-1:0]           cand_reg;
    logic [DW-1:0]                    d_reg;
    logic [SW-1:0]                    sq_reg;
    logic [lpam_pkg::FIELD_WIDTH-1:0] result_reg;
    logic                             out_valid_reg;

    logic [VALUE_WIDTH-1:0]           limit;
    logic [VALUE_WIDTH-1:0]           cand_first;
    logic                             div_busy;
    logic                             rem_zero;

    // First candidate: limit itself if odd, one less if even, 1 if under three
    always_comb begin
        limit = s_upper_limit[VALUE_WIDTH-1:0];
        if (limit < VALUE_WIDTH'(3)) begin
            cand_first = VALUE_WIDTH'(lpam_pkg::NO_PRIME);
        end else if (limit[0]) begin
            cand_first = limit;
        end else begin
            cand_first = limit - VALUE_WIDTH'(1);
        end
    end

    // Candidate register; it doubles as the answer when it reaches 1
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cand_reg <= cand_first;
        end else if (cmd.cand_step) begin
            cand_reg <= cand_reg - VALUE_WIDTH'(2);
        end
    end

    // Divisor and its square, (d+2)^2 = d^2 + 4d + 4
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            d_reg  <= DW'(lpam_pkg::FIRST_DIVISOR);
            sq_reg <= SW'(lpam_pkg::FIRST_DIVISOR * lpam_pkg::FIRST_DIVISOR);
        end else if (cmd.div_step) begin
            d_reg  <= d_reg + DW'(2);
            sq_reg <= sq_reg + (SW'(d_reg) << 2) + SW'(4);
        end
    end

    // Remainder unit: cand % d, one quotient bit per cycle
    lpam_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cand_reg),
        .divisor  (d_reg),
        .busy     (div_busy),
        .rem_zero (rem_zero)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            result_reg <= lpam_pkg::FIELD_WIDTH'(cand_reg);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_largest_prime = result_reg;

    always_comb begin
        status.cand_lt3   = (cand_reg < VALUE_WIDTH'(3));
        status.sq_gt_cand = (sq_reg > SW'(cand_reg));
        status.div_busy   = div_busy;
        status.rem_zero   = rem_zero;
        status.out_free   = !out_valid_reg || m_ready;
    end

    // Every answer is odd: an odd prime or 1
    a_result_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> result_reg[0])
        else $error("even result presented");

    // A pending beat is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("output beat overwritten");

endmodule

// File: sv/lpam_ctrl.sv
module lpam_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output lpam_pkg::lpam_cmd_t    cmd,
    input  lpam_pkg::lpam_status_t status
);

    lpam_pkg::lpam_state_t state_reg;
    lpam_pkg::lpam_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpam_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpam_pkg::ST_IDLE: begin
                if (s_valid) state_next = lpam_pkg::ST_SETUP;
            end
            lpam_pkg::ST_SETUP: begin
                state_next = status.cand_lt3 ? lpam_pkg::ST_FINISH : lpam_pkg::ST_TEST;
            end
            lpam_pkg::ST_TEST: begin
                state_next = status.sq_gt_cand ? lpam_pkg::ST_FINISH : lpam_pkg::ST_DIV;
            end
            lpam_pkg::ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = status.rem_zero ? lpam_pkg::ST_SETUP : lpam_pkg::ST_TEST;
                end
            end
            lpam_pkg::ST_FINISH: begin
                if (status.out_free) state_next = lpam_pkg::ST_IDLE;
            end
            default: state_next = lpam_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            lpam_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            lpam_pkg::ST_SETUP: begin
                cmd.div_init = !status.cand_lt3;
            end
            lpam_pkg::ST_TEST: begin
                cmd.div_start = !status.sq_gt_cand;
            end
            lpam_pkg::ST_DIV: begin
                if (!status.div_busy) begin
                    cmd.cand_step = status.rem_zero;
                    cmd.div_step  = !status.rem_zero;
                end
            end
            lpam_pkg::ST_FINISH: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Once a division is launched, the controller is in the division state and the remainder unit is running
    a_div_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (state_reg == lpam_pkg::ST_DIV) && status.div_busy)
        else $error("division not running after launch");

endmodule

// File: sv/largest_prime_at_most_core.sv
// Channel  Ports                                  Dir  Payload
// -------  -------------------------------------  ---  ------------------------
// input    s_valid, s_ready, s_upper_limit        in   32-bit limit, unsigned
// result   m_valid, m_ready, m_largest_prime      out  32-bit odd prime or 1
//
// One item at a time: the idle state accepts a limit, then each odd candidate passes
// the setup state and, per trial divisor d = 3, 5, ... with d*d <= candidate, the test
// state and the division state (shift-subtract steps, decision); the prime found takes
// a last test, then the finish state loads the output.
// aresetn is synchronous, active low; clears controller, divider busy and m_valid.
// A stalled result beat holds the finish state; next limit taken once it is loaded.
module largest_prime_at_most_core #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lpam_pkg::FIELD_WIDTH-1:0] s_upper_limit,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lpam_pkg::FIELD_WIDTH-1:0] m_largest_prime
);

    lpam_pkg::lpam_cmd_t    cmd;
    lpam_pkg::lpam_status_t status;

    lpam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    lpam_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_upper_limit   (s_upper_limit),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_largest_prime (m_largest_prime)
    );

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALUE_WIDTH = 32;
    localparam longint unsigned LIMIT_MASK = (64'd1 << VALUE_WIDTH) - 1;
    localparam int unsigned MAX_IDLE = 18;
    localparam int unsigned HOLD_CYCLES = 1000;
    localparam int unsigned TAIL_CYCLES = 200;
    // slowest item: the limit at full scale
    localparam int unsigned STALL_LIMIT = 10_000_000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic [lpam_pkg::FIELD_WIDTH-1:0] limit;
        logic [lpam_pkg::FIELD_WIDTH-1:0] prime;
    } prime_expect_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [lpam_pkg::FIELD_WIDTH-1:0] s_upper_limit = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [lpam_pkg::FIELD_WIDTH-1:0] m_largest_prime;

    prime_expect_t expected_primes[$];
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles = 0;
    bit            tx_idle = 1'b1;
    bit            rx_idle = 1'b1;
    bit            hold_request = 1'b0;

    always #2 aclk = ~aclk;

    largest_prime_at_most_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_upper_limit  (s_upper_limit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_largest_prime(m_largest_prime)
    );

    // Largest odd prime at or below the limit, 1 when there is none
    function automatic logic [lpam_pkg::FIELD_WIDTH-1:0] largest_odd_prime_upto(
        input logic [lpam_pkg::FIELD_WIDTH-1:0] limit_in
    );
        longint unsigned limit;
        longint unsigned cand;
        longint unsigned divisor;
        bit              is_prime;
        limit = longint'(limit_in) & LIMIT_MASK;
        if (limit < 3)
            return lpam_pkg::FIELD_WIDTH'(lpam_pkg::NO_PRIME);
        cand = limit[0] ? limit : limit - 1;
        while (cand >= 3) begin
            is_prime = 1'b1;
            // odd candidates only: even divisors never hit
            for (divisor = lpam_pkg::FIRST_DIVISOR; divisor * divisor <= cand;
                 divisor += 2) begin
                if (cand % divisor == 0) begin
                    is_prime = 1'b0;
                    break;
                end
            end
            if (is_prime)
                return cand[lpam_pkg::FIELD_WIDTH-1:0];
            cand -= 2;
        end
        return lpam_pkg::FIELD_WIDTH'(lpam_pkg::NO_PRIME);
    endfunction

    // Mostly narrow limits so the search stays short; a few reach 20 bits
    function automatic logic [lpam_pkg::FIELD_WIDTH-1:0] random_limit();
        int unsigned                      nbits;
        logic [lpam_pkg::FIELD_WIDTH-1:0] mask;
        nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
        mask = (lpam_pkg::FIELD_WIDTH'(1) << nbits) - 1;
        return $urandom & mask;
    endfunction

    // Send one limit beat; called just after a rising edge
    task automatic send_limit(input logic [lpam_pkg::FIELD_WIDTH-1:0] limit);
        int unsigned   gap;
        prime_expect_t exp_item;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_upper_limit <= limit;
        do @(posedge aclk); while (!(s_valid && s_ready));
        exp_item.limit = limit;
        exp_item.prime = largest_odd_prime_upto(limit);
        expected_primes.push_back(exp_item);
    endtask

    // Drop valid after the last beat of a burst
    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (expected_primes.size() != 0)
            @(posedge aclk);
    endtask

    // Field extremes, small limits, squares of primes, full scale last
    task automatic test_directed_limits();
        logic [lpam_pkg::FIELD_WIDTH-1:0] limits[$];
        limits = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9,
                   32'd25, 32'd49, 32'd120, 32'd121, 32'd169, 32'd1000,
                   32'd65535, 32'd65536, 32'h5555_5555 & 32'h0000_FFFF,
                   32'hAAAA & 32'hFFFF, 32'hFFFF_FFFF};
        foreach (limits[i])
            send_limit(limits[i]);
        stop_sending();
        wait_results();
    endtask

    // Receiver holds off while short searches keep coming: block must stall input
    task automatic test_backpressure_fill();
        hold_request = 1'b1;
        tx_idle = 1'b0;
        repeat (10)
            send_limit($urandom_range(0, 63));
        stop_sending();
        wait_results();
        tx_idle = 1'b1;
    endtask

    // Random limits across idle patterns, including stretches with no gaps
    task automatic test_random_limits();
        for (int phase = 0; phase < 4; phase++) begin
            tx_idle = (phase == 0) || (phase == 1);
            rx_idle = (phase == 0) || (phase == 2);
            repeat (18)
                send_limit(random_limit());
        end
        stop_sending();
        wait_results();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Result receiver: random stalls per beat, plus one long hold on request
    initial begin
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && !hold_request);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        prime_expect_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (expected_primes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result beat: largest_prime %0d", m_largest_prime);
            end else begin
                exp_item = expected_primes.pop_front();
                if (m_largest_prime !== exp_item.prime) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: limit %0d expected %0d got %0d",
                                 exp_item.limit, exp_item.prime, m_largest_prime);
                end
            end
        end
    end

    // Watchdog: no beat on either channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_limits();
        test_backpressure_fill();
        test_random_limits();
        // look for stray beats after the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_primes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
